// File: src/trs_pkg.sv
// Shared types and constants for the tank refill sequencer.
// No dependencies; imported by trs_core, tank_refill_sequencer_unit and the testbench.
package trs_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int CHANNELS_MAX = 8;
    localparam int LEVEL_W      = 10;
    localparam int CNT_W        = 4;
    localparam int TICK_W       = 16;
    localparam int CHAN_OUT_W   = 3;
    localparam int MASK_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 24;

    localparam logic [LEVEL_W-1:0] DETECT_LEVEL_RST = 10'd512;
    localparam logic [CNT_W-1:0]   EMPTY_NEEDED_RST = 4'd3;
    localparam logic [TICK_W-1:0]  TICK_LIMIT_RST   = 16'd60;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED     = 3'd0,
        ST_SKIPPED     = 3'd1,
        ST_NOT_EMPTY   = 3'd2,
        ST_EMPTY_COUNT = 3'd3,
        ST_FILL_START  = 3'd4,
        ST_FILLING     = 3'd5,
        ST_FILLED      = 3'd6,
        ST_TIMED_OUT   = 3'd7
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_LEVEL = 2'd0,
        CFG_EMPTY_NEEDED = 2'd1,
        CFG_TICK_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] detect_level;
        logic [CNT_W-1:0]   empty_needed;
        logic [TICK_W-1:0]  tick_limit;
    } t_cfg;

    typedef struct packed {
        logic [MASK_W-1:0]     timed_out_mask;
        logic                  valve_on;
        logic                  filling;
        logic [CHAN_OUT_W-1:0] next_channel;
        logic [CHAN_OUT_W-1:0] checked_channel;
        t_status               status;
    } t_result;

endpackage

// File: src/trs_core.sv
// Sequencer state and per-word update: round-robin checks, empty counting,
// fill tick timing and timeout latching. Depends on trs_pkg.
module trs_core #(
    parameter int CHANNELS = trs_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trs_pkg::t_cfg                 i_cfg,
    input  logic                          i_step,
    input  logic                          i_cmd,
    input  logic                          i_connected,
    input  logic [trs_pkg::LEVEL_W-1:0]   i_level,
    output trs_pkg::t_result              o_result
);
    import trs_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic                r_filling, n_filling;
    logic [CH_W-1:0]     r_ptr, n_ptr;
    logic [CH_W-1:0]     r_fill_ch, n_fill_ch;
    logic [CNT_W-1:0]    r_cnt [CHANNELS];
    logic [CNT_W-1:0]    n_cnt [CHANNELS];
    logic [CHANNELS-1:0] r_timeout, n_timeout;
    logic [TICK_W-1:0]   r_ticks, n_ticks;

    logic [CH_W-1:0]   chk_ch;
    logic [CH_W-1:0]   res_ch;
    logic [CNT_W-1:0]  cnt_inc;
    logic [TICK_W-1:0] tick_inc;
    t_status           status;

    function automatic logic [CH_W-1:0] next_of(input logic [CH_W-1:0] p);
        return (p == LAST_CH) ? '0 : p + CH_W'(1);
    endfunction

    always_comb begin
        n_filling = r_filling;
        n_ptr     = r_ptr;
        n_fill_ch = r_fill_ch;
        n_cnt     = r_cnt;
        n_timeout = r_timeout;
        n_ticks   = r_ticks;
        status    = ST_IGNORED;
        res_ch    = '0;

        chk_ch   = next_of(r_ptr);
        cnt_inc  = (r_cnt[chk_ch] == '1) ? r_cnt[chk_ch] : r_cnt[chk_ch] + CNT_W'(1);
        tick_inc = (r_ticks == '1) ? r_ticks : r_ticks + TICK_W'(1);

        if (i_cmd == CMD_CHECK && !r_filling) begin
            n_ptr  = chk_ch;
            res_ch = chk_ch;
            if (r_timeout[chk_ch] || !i_connected) begin
                status = ST_SKIPPED;
            end else if (i_level < i_cfg.detect_level) begin
                if (cnt_inc >= i_cfg.empty_needed) begin
                    n_cnt[chk_ch] = '0;
                    n_fill_ch     = chk_ch;
                    n_ticks       = '0;
                    n_filling     = 1'b1;
                    status        = ST_FILL_START;
                end else begin
                    n_cnt[chk_ch] = cnt_inc;
                    status        = ST_EMPTY_COUNT;
                end
            end else begin
                n_cnt[chk_ch] = '0;
                status        = ST_NOT_EMPTY;
            end
        end else if (i_cmd == CMD_TICK && r_filling) begin
            res_ch = r_fill_ch;
            if (i_level > i_cfg.detect_level) begin
                n_filling = 1'b0;
                status    = ST_FILLED;
            end else begin
                n_ticks = tick_inc;
                if (tick_inc >= i_cfg.tick_limit) begin
                    n_timeout[r_fill_ch] = 1'b1;
                    n_filling            = 1'b0;
                    status               = ST_TIMED_OUT;
                end else begin
                    status = ST_FILLING;
                end
            end
        end

        o_result.status          = status;
        o_result.checked_channel = CHAN_OUT_W'(res_ch);
        o_result.next_channel    = CHAN_OUT_W'(next_of(n_ptr));
        o_result.filling         = n_filling;
        o_result.valve_on        = n_filling;
        o_result.timed_out_mask  = MASK_W'(n_timeout);
    end

    // advance state only when a word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling <= 1'b0;
            r_ptr     <= LAST_CH;
            r_fill_ch <= '0;
            r_timeout <= '0;
            r_ticks   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_step) begin
            r_filling <= n_filling;
            r_ptr     <= n_ptr;
            r_fill_ch <= n_fill_ch;
            r_timeout <= n_timeout;
            r_ticks   <= n_ticks;
            r_cnt     <= n_cnt;
        end
    end

endmodule

// File: src/tank_refill_sequencer_unit.sv
// Top level of the tank refill sequencer: stream ports, input and result
// registers, configuration registers. Depends on trs_pkg and trs_core.

// Each input word gives exactly one result word, passed through the input register
// and then the result register; the block takes a new word every cycle while the
// result port is not stalled, with a single update of per-channel state between
// the input register and the result register.
// A check word (tuser 0) while waiting samples the next channel round robin;
// a tick word (tuser 1) while filling samples the filling channel. Words that
// do not match the current mode return status 0 and change nothing.
// Configuration writes are taken at any time, one per cycle, and should be
// made only while no word is in flight.
module tank_refill_sequencer_unit #(
    parameter int CHANNELS = trs_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [trs_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // [0] connected, [10:1] level
    input  logic [0:0]                       i_s_axis_tuser,  // [0] cmd
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [2:0] status, [5:3] checked_channel, [8:6] next_channel, [9] filling,
    // [10] valve_on, [18:11] timed_out_mask
    output logic [trs_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import trs_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic               r_in_cmd;
    logic               r_in_connected;
    logic [LEVEL_W-1:0] r_in_level;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;
    logic               out_adv;
    logic               step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.detect_level <= DETECT_LEVEL_RST;
            r_cfg.empty_needed <= EMPTY_NEEDED_RST;
            r_cfg.tick_limit   <= TICK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DETECT_LEVEL: r_cfg.detect_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_EMPTY_NEEDED: r_cfg.empty_needed <= i_cfg_data[CNT_W-1:0];
                CFG_TICK_LIMIT:   r_cfg.tick_limit   <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // result register frees when empty or taken; input register follows it
    assign out_adv         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_adv;
    assign o_s_axis_tready = !r_in_valid || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_cmd       <= i_s_axis_tuser[0];
            r_in_connected <= i_s_axis_tdata[0];
            r_in_level     <= i_s_axis_tdata[LEVEL_W:1];
        end
    end

    trs_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (step),
        .i_cmd       (r_in_cmd),
        .i_connected (r_in_connected),
        .i_level     (r_in_level),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out);

endmodule

// File: dv/tb_tank_refill_sequencer_unit.sv
// Self-checking testbench for tank_refill_sequencer_unit: directed words, then random
// check/tick traffic over several register settings, scored against an in-bench model.
// Depends on trs_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_tank_refill_sequencer_unit;
    import trs_pkg::*;

    localparam int CH          = CHANNELS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RES_W       = $bits(t_result);
    localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;

    typedef struct packed {
        logic               cmd;
        logic               conn;
        logic [LEVEL_W-1:0] level;
    } t_word;

    typedef struct {
        t_word   w;
        bit      typed;
        t_result exp;
    } t_row;

    typedef struct {
        int detect;
        int needed;
        int limit;
        int items;
        int to_mode;    // 0 no timeouts, 1 only on channel 1, 2 on any channel
        int empty_pct;
    } t_phase;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [0:0]            i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    tank_refill_sequencer_unit #(.CHANNELS(CH)) dut (.*);

    // model state and register copies
    logic [LEVEL_W-1:0] cfg_detect = DETECT_LEVEL_RST;
    logic [CNT_W-1:0]   cfg_needed = EMPTY_NEEDED_RST;
    logic [TICK_W-1:0]  cfg_limit  = TICK_LIMIT_RST;
    bit                 pr_filling = 1'b0;
    int                 pr_ptr     = CH - 1;
    int                 pr_fill_ch = 0;
    int                 pr_ticks   = 0;
    int                 pr_cnt [CH];
    bit                 pr_to  [CH];

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      burst_left = 1;
    int      gap_left = 0;
    int      to_mode = 0;
    int      empty_pct = 60;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    int unsigned cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int next_of(int p);
        return (p + 1 >= CH) ? 0 : p + 1;
    endfunction

    function automatic t_result mk_res(t_status st, int chk, int nxt, bit fill,
                                       logic [MASK_W-1:0] m);
        t_result r;
        r.status          = st;
        r.checked_channel = CHAN_OUT_W'(chk);
        r.next_channel    = CHAN_OUT_W'(nxt);
        r.filling         = fill;
        r.valve_on        = fill;
        r.timed_out_mask  = m;
        return r;
    endfunction

    // Advance the sequencer state by one accepted word and return its result.
    function automatic t_result refill_outcome(t_word w);
        t_status           st;
        int                ch;
        int                c;
        logic [MASK_W-1:0] m;
        st = ST_IGNORED;
        ch = 0;
        if (w.cmd == CMD_CHECK && !pr_filling) begin
            c = next_of(pr_ptr);
            pr_ptr = c;
            ch = c;
            if (pr_to[c] || !w.conn) begin
                st = ST_SKIPPED;
            end else if (w.level < cfg_detect) begin
                if (pr_cnt[c] < 15) pr_cnt[c]++;
                if (pr_cnt[c] >= cfg_needed) begin
                    pr_cnt[c]  = 0;
                    pr_fill_ch = c;
                    pr_ticks   = 0;
                    pr_filling = 1'b1;
                    st = ST_FILL_START;
                end else begin
                    st = ST_EMPTY_COUNT;
                end
            end else begin
                pr_cnt[c] = 0;
                st = ST_NOT_EMPTY;
            end
        end else if (w.cmd == CMD_TICK && pr_filling) begin
            ch = pr_fill_ch;
            if (w.level > cfg_detect) begin
                pr_filling = 1'b0;
                st = ST_FILLED;
            end else begin
                if (pr_ticks < 65535) pr_ticks++;
                if (pr_ticks >= cfg_limit) begin
                    pr_to[pr_fill_ch] = 1'b1;
                    pr_filling = 1'b0;
                    st = ST_TIMED_OUT;
                end else begin
                    st = ST_FILLING;
                end
            end
        end
        m = '0;
        for (int i = 0; i < CH; i++) m[i] = pr_to[i];
        return mk_res(st, ch, next_of(pr_ptr), pr_filling, m);
    endfunction

    function automatic bit timeout_ok(int ch);
        return to_mode == 2 || (to_mode == 1 && ch == 1);
    endfunction

    // Mostly well-formed traffic for the current mode; a few words of the wrong kind.
    function automatic t_word pick_word();
        t_word w;
        int    nxt;
        bit    fill_ok;
        nxt = next_of(pr_ptr);
        w.conn  = ($urandom_range(7) != 0);
        w.level = LEVEL_W'($urandom);
        if ($urandom_range(99) < 8) begin
            w.cmd = pr_filling ? CMD_CHECK : CMD_TICK;
            return w;
        end
        if (!pr_filling) begin
            w.cmd = CMD_CHECK;
            if (cfg_detect == LEVEL_MAX && !timeout_ok(nxt))
                w.level = LEVEL_W'(LEVEL_MAX);
            else if (cfg_detect != 0 && $urandom_range(99) < empty_pct)
                w.level = LEVEL_W'($urandom_range(int'(cfg_detect) - 1, 0));
            else
                w.level = LEVEL_W'($urandom_range(LEVEL_MAX, int'(cfg_detect)));
        end else begin
            w.cmd = CMD_TICK;
            fill_ok = (cfg_detect != LEVEL_MAX);
            // force the fill on the last allowed tick unless a timeout is welcome here
            if (fill_ok && ($urandom_range(99) < 15 ||
                    (!timeout_ok(pr_fill_ch) && pr_ticks + 1 >= cfg_limit)))
                w.level = LEVEL_W'($urandom_range(LEVEL_MAX, int'(cfg_detect) + 1));
            else
                w.level = LEVEL_W'($urandom_range(int'(cfg_detect), 0));
        end
        return w;
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t ns: result %0d %s got %0d want %0d", $realtime, results_seen,
                 what, got, want);
    endtask

    task automatic send_word(t_word w, bit typed, t_result exp, output t_status st);
        t_result pred;
        while (gap_left > 0) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            gap_left--;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_DATA_W'({w.level, w.conn});
        i_s_axis_tuser  <= w.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pred = refill_outcome(w);
        pending_results.push_back(typed ? exp : pred);
        st = pred.status;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(30, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end
    endtask

    // Hold the input side until every pending result is out, then let the pipe settle.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(int detect, int needed, int limit);
        t_cfg_idx regs [3];
        int       vals [3];
        regs = '{CFG_DETECT_LEVEL, CFG_EMPTY_NEEDED, CFG_TICK_LIMIT};
        vals = '{detect, needed, limit};
        drain_results();
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= CFG_DATA_W'(vals[k]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (regs[k])
                CFG_DETECT_LEVEL: cfg_detect = LEVEL_W'(vals[k]);
                CFG_EMPTY_NEEDED: cfg_needed = CNT_W'(vals[k]);
                CFG_TICK_LIMIT:   cfg_limit  = TICK_W'(vals[k]);
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(logic cmd, logic conn, int level, bit typed, t_result exp);
        t_row r;
        r.w     = '{cmd: cmd, conn: conn, level: LEVEL_W'(level)};
        r.typed = typed;
        r.exp   = exp;
        directed_rows.push_back(r);
    endtask

    // receiver: ready pattern changes every window
    int       win_left = 0;
    int       rdy_mode = 0;
    bit [7:0] rdy_pat  = '0;
    always @(posedge i_clk) begin
        if (win_left == 0) begin
            win_left = $urandom_range(80, 10);
            rdy_mode = $urandom_range(3);
            rdy_pat  = 8'($urandom);
        end
        win_left--;
        case (rdy_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(9) < 7);
            2: i_m_axis_tready <= ($urandom_range(3) == 0);
            default: begin
                rdy_pat = {rdy_pat[6:0], rdy_pat[7]};
                i_m_axis_tready <= rdy_pat[0];
            end
        endcase
    end

    always @(posedge i_clk) begin : score
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                note_mismatch("word with nothing pending, status", got.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    note_mismatch("status", got.status, want.status);
                if (got.checked_channel !== want.checked_channel)
                    note_mismatch("checked_channel", got.checked_channel,
                                  want.checked_channel);
                if (got.next_channel !== want.next_channel)
                    note_mismatch("next_channel", got.next_channel, want.next_channel);
                if (got.filling !== want.filling)
                    note_mismatch("filling", got.filling, want.filling);
                if (got.valve_on !== want.valve_on)
                    note_mismatch("valve_on", got.valve_on, want.valve_on);
                if (got.timed_out_mask !== want.timed_out_mask)
                    note_mismatch("timed_out_mask", got.timed_out_mask, want.timed_out_mask);
                if (o_m_axis_tdata[OUT_DATA_W-1:RES_W] !== '0)
                    note_mismatch("padding", o_m_axis_tdata[OUT_DATA_W-1:RES_W], 0);
            end
            results_seen++;
        end
    end

    initial begin : stim
        t_phase  phases [7];
        t_status st;
        int      done;
        for (int i = 0; i < CH; i++) begin
            pr_cnt[i] = 0;
            pr_to[i]  = 1'b0;
        end

        // reset settings: threshold 512, three empties, 60 ticks
        add_row(CMD_TICK,  1'b0, 0,    1, mk_res(ST_IGNORED,   0, 0, 0, '0));
        add_row(CMD_CHECK, 1'b0, 0,    1, mk_res(ST_SKIPPED,   0, 1, 0, '0));
        add_row(CMD_CHECK, 1'b1, 1023, 1, mk_res(ST_NOT_EMPTY, 1, 0, 0, '0));
        add_row(CMD_CHECK, 1'b1, 0,    0, '0);
        add_row(CMD_CHECK, 1'b1, 512,  0, '0);   // at threshold counts as not empty
        add_row(CMD_CHECK, 1'b1, 511,  0, '0);
        add_row(CMD_CHECK, 1'b0, 1023, 0, '0);   // skip leaves the count alone
        add_row(CMD_CHECK, 1'b1, 0,    0, '0);   // third empty on channel 0 opens the valve
        add_row(CMD_CHECK, 1'b1, 1023, 0, '0);   // check while filling is dropped
        add_row(CMD_TICK,  1'b1, 512,  0, '0);
        add_row(CMD_TICK,  1'b1, 1023, 1, mk_res(ST_FILLED,  0, 1, 0, '0));
        add_row(CMD_TICK,  1'b1, 1023, 1, mk_res(ST_IGNORED, 0, 1, 0, '0));
        add_row(CMD_CHECK, 1'b1, 0,    0, '0);
        add_row(CMD_CHECK, 1'b1, 1023, 0, '0);

        phases[0] = '{512, 3, 60, 300, 0, 60};
        phases[1] = '{0, 1, 1, 80, 0, 50};
        phases[2] = '{300, 1, 1, 300, 0, 50};
        phases[3] = '{700, 15, 65535, 300, 0, 95};
        phases[4] = '{$urandom_range(1022, 1), $urandom_range(15, 1),
                      $urandom_range(40, 1), 300, 0, 70};
        phases[5] = '{1023, 1, 1, 120, 1, 50};
        phases[6] = '{512, 2, 20, 300, 2, 60};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].exp, st);

        foreach (phases[p]) begin
            // close any open fill under the old settings before switching
            while (pr_filling)
                send_word('{cmd: CMD_TICK, conn: 1'b1, level: LEVEL_W'(LEVEL_MAX)}, 0, '0, st);
            configure(phases[p].detect, phases[p].needed, phases[p].limit);
            to_mode   = phases[p].to_mode;
            empty_pct = phases[p].empty_pct;
            done = 0;
            while (done < phases[p].items) begin
                send_word(pick_word(), 0, '0, st);
                if (st != ST_IGNORED) done++;
                if (p == 0 && done == phases[p].items / 2 && st != ST_IGNORED)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
